// ===== design/mtww_pkg.sv =====
// ----------------------------------------------------------------------------
// mtww_pkg: shared types for the windowed task watchdog
// Configuration record, register indexes, operation codes and the result record.
// ----------------------------------------------------------------------------
package mtww_pkg;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned MASK_W      = 32;
	localparam int unsigned ID_W        = 5;
	localparam int unsigned SAMPLE_W    = 64;

	typedef enum logic {
		OP_CHECKIN = 1'b0,
		OP_PERIOD  = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WATCH_MASK   = 8'd0,
		REG_ENABLE_RESET = 8'd1,
		REG_WINDOW_LOW   = 8'd2,
		REG_WINDOW_HIGH  = 8'd3
	} cfg_index_t;

	typedef struct packed {
		logic [MASK_W-1:0]   watch_mask;
		logic                enable_reset;
		logic [SAMPLE_W-1:0] window_low;
		logic [SAMPLE_W-1:0] window_high;
	} cfg_t;

	typedef struct packed {
		logic [MASK_W-1:0] dead_mask;
		logic              timing_fault;
		logic              panic;
		logic              halt;
		logic              kick;
	} result_t;

endpackage

// ===== design/mtww_item_if.sv =====
// ----------------------------------------------------------------------------
// mtww_item_if: request channel into the watchdog
// Valid/ready handshake carrying a check-in or a period request.
// ----------------------------------------------------------------------------
interface mtww_item_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [mtww_pkg::ID_W-1:0]         task_id;
	logic [mtww_pkg::SAMPLE_W-1:0]     timing_sample;

	modport source (output valid, output operation, output task_id, output timing_sample,
		input ready);
	modport sink (input valid, input operation, input task_id, input timing_sample,
		output ready);
endinterface

// ===== design/mtww_result_if.sv =====
// ----------------------------------------------------------------------------
// mtww_result_if: result channel out of the watchdog
// Valid/ready handshake carrying one period verdict.
// ----------------------------------------------------------------------------
interface mtww_result_if;
	logic                          valid;
	logic                          ready;
	logic [mtww_pkg::MASK_W-1:0]   dead_mask;
	logic                          timing_fault;
	logic                          panic;
	logic                          halt;
	logic                          kick;

	modport source (output valid, output dead_mask, output timing_fault, output panic,
		output halt, output kick, input ready);
	modport sink (input valid, input dead_mask, input timing_fault, input panic,
		input halt, input kick, output ready);
endinterface

// ===== design/multi_task_windowed_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_task_windowed_watchdog: windowed check-in watchdog for up to TASKS tasks
// Requests enter on item, verdicts leave on result, registers load via cfg_*.
// ----------------------------------------------------------------------------
// A check-in request sets its task's bit and gives no verdict. A period request
// carries a timing counter sample; the first one after reset only records the
// baseline, each later one gives a verdict: dead mask (check-ins XOR watch
// mask), timing fault when the 64-bit wrapping advance lies outside
// [window_low, window_high], panic, and halt or kick when enable_reset is set.
// A verdict passes through the request register and then the result register
// before it appears on result.
// Throughput: one request per cycle while item.ready is high; the state is
// updated at the request register. A verdict held in the result register
// does not stop the next request from being taken; while the receiver
// stalls with a verdict waiting in both registers, item.ready drops.
// Reset clears check-ins, the baseline and the registers to their defaults.
// Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module multi_task_windowed_watchdog #(
	parameter int unsigned TASKS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mtww_item_if.sink                           item,
	mtww_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [mtww_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mtww_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mtww_pkg::cfg_t    cfg;
	mtww_pkg::result_t res;
	mtww_pkg::result_t out_res;
	logic              res_valid;
	logic              res_ready;

	mtww_cfg #(.TASKS(TASKS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mtww_eval #(.TASKS(TASKS)) u_eval (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.in_valid         (item.valid),
		.in_ready         (item.ready),
		.in_operation     (item.operation),
		.in_task_id       (item.task_id),
		.in_timing_sample (item.timing_sample),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res              (res)
	);

	mtww_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (out_res)
	);

	assign result.dead_mask    = out_res.dead_mask;
	assign result.timing_fault = out_res.timing_fault;
	assign result.panic        = out_res.panic;
	assign result.halt         = out_res.halt;
	assign result.kick         = out_res.kick;

endmodule

// ===== design/mtww_cfg.sv =====
// ----------------------------------------------------------------------------
// mtww_cfg: configuration register file
// Decodes plain writes into the watch mask, reset enable and timing window.
// ----------------------------------------------------------------------------
module mtww_cfg #(
	parameter int unsigned TASKS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mtww_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mtww_pkg::CFG_DATA_W-1:0]     cfg_data,
	output mtww_pkg::cfg_t                      cfg
);

	localparam logic [mtww_pkg::MASK_W-1:0] WATCH_RESET =
		mtww_pkg::MASK_W'((65'd1 << TASKS) - 65'd1);

	mtww_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_mask   <= WATCH_RESET;
			cfg_q.enable_reset <= 1'b1;
			cfg_q.window_low   <= '0;
			cfg_q.window_high  <= '1;
		end else if (cfg_we) begin
			case (mtww_pkg::cfg_index_t'(cfg_index))
				mtww_pkg::REG_WATCH_MASK:   cfg_q.watch_mask   <= cfg_data[mtww_pkg::MASK_W-1:0];
				mtww_pkg::REG_ENABLE_RESET: cfg_q.enable_reset <= cfg_data[0];
				mtww_pkg::REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_data;
				mtww_pkg::REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/mtww_eval.sv =====
// ----------------------------------------------------------------------------
// mtww_eval: request register, watchdog state and period verdict
// Holds one request, updates check-in bits and the timing baseline, and forms
// the verdict for each counted period.
// ----------------------------------------------------------------------------
module mtww_eval #(
	parameter int unsigned TASKS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtww_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_operation,
	input  logic [mtww_pkg::ID_W-1:0]           in_task_id,
	input  logic [mtww_pkg::SAMPLE_W-1:0]       in_timing_sample,
	output logic                                res_valid,
	input  logic                                res_ready,
	output mtww_pkg::result_t                   res
);

	logic                              valid_s1;
	mtww_pkg::op_t                     op_s1;
	logic [mtww_pkg::ID_W-1:0]         id_s1;
	logic [mtww_pkg::SAMPLE_W-1:0]     sample_s1;

	logic [TASKS-1:0]                  checkin_q;
	logic [mtww_pkg::SAMPLE_W-1:0]     prev_q;
	logic                              baseline_q;

	logic                              advance;
	logic                              id_ok;
	logic [mtww_pkg::SAMPLE_W-1:0]     delta;
	logic                              fault;
	logic [mtww_pkg::MASK_W-1:0]       dead;
	logic                              panic;

	assign res_valid = valid_s1 && (op_s1 == mtww_pkg::OP_PERIOD) && baseline_q;
	// Requests that give no result always drain; a verdict waits for the output slot.
	assign advance   = !valid_s1 || !res_valid || res_ready;
	assign in_ready  = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			op_s1     <= mtww_pkg::op_t'(in_operation);
			id_s1     <= in_task_id;
			sample_s1 <= in_timing_sample;
		end
	end

	assign id_ok = {1'b0, id_s1} < (mtww_pkg::ID_W + 1)'(TASKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checkin_q  <= '0;
			prev_q     <= '0;
			baseline_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			case (op_s1)
				mtww_pkg::OP_CHECKIN: begin
					if (id_ok) begin
						checkin_q <= checkin_q | (TASKS'(1) << id_s1);
					end
				end
				mtww_pkg::OP_PERIOD: begin
					prev_q     <= sample_s1;
					baseline_q <= 1'b1;
					// The first period only sets the baseline and keeps the check-ins.
					if (baseline_q) begin
						checkin_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign delta = sample_s1 - prev_q;
	assign fault = (delta < cfg.window_low) || (delta > cfg.window_high);
	assign dead  = mtww_pkg::MASK_W'(checkin_q) ^ cfg.watch_mask;
	assign panic = (dead != '0) || fault;

	assign res.dead_mask    = dead;
	assign res.timing_fault = fault;
	assign res.panic        = panic;
	assign res.halt         = panic && cfg.enable_reset;
	assign res.kick         = !panic && cfg.enable_reset;

endmodule

// ===== design/mtww_out.sv =====
// ----------------------------------------------------------------------------
// mtww_out: result register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module mtww_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_ready,
	input  mtww_pkg::result_t   res,
	output logic                out_valid,
	input  logic                out_ready,
	output mtww_pkg::result_t   out_res
);

	logic              valid_q;
	mtww_pkg::result_t res_q;

	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
